@@ hdl/penalty_proximal_threshold_macros.svh @@
// Assertion macros shared by the proximal threshold RTL.
// Expects signals clk and rst in the scope that uses them.
`ifndef PENALTY_PROXIMAL_THRESHOLD_MACROS_SVH
`define PENALTY_PROXIMAL_THRESHOLD_MACROS_SVH

// same-cycle implication
`define PPT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PPT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/ppt_pkg.sv @@
// Shared constants and types for the proximal threshold block.
// No dependencies.
`timescale 1ns / 1ps
package ppt_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int DIV_W         = 64;
  localparam int Q_DEPTH       = 4;   // power of two, pointers wrap naturally
  localparam int Q_AW          = $clog2(Q_DEPTH);
  localparam int Q_CW          = $clog2(Q_DEPTH + 1);
  localparam int PADDR_W       = 4;
  localparam logic [23:0] GAMMA_RESET = 24'd242483;

  typedef enum logic [1:0] {
    MODE_LASSO = 2'd0,
    MODE_MCP   = 2'd1,
    MODE_SCAD  = 2'd2,
    MODE_RIDGE = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    REG_MODE   = 2'd0,
    REG_LAMBDA = 2'd1,
    REG_GAMMA  = 2'd2
  } reg_idx_t;

  localparam logic [1:0] ZONE_ZERO   = 2'd0;
  localparam logic [1:0] ZONE_SOFT   = 2'd1;
  localparam logic [1:0] ZONE_SCALED = 2'd2;
  localparam logic [1:0] ZONE_KEPT   = 2'd3;

  typedef struct packed {
    mode_t       mode;
    logic [31:0] lambda;
    logic [23:0] gamma;
  } ppt_cfg_t;

  // classified item: back end computes dividend / divisor then signs it
  typedef struct packed {
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
    logic             neg;
    logic [1:0]       zone;
    logic             err;
  } ppt_item_t;

endpackage

@@ hdl/ppt_if.sv @@
// Valid/ready channel interfaces for input items and results.
// No dependencies.
`timescale 1ns / 1ps
interface ppt_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] coefficient;
  logic        [31:0] weight;
  modport source (output valid, coefficient, weight, input ready);
  modport sink   (input valid, coefficient, weight, output ready);
endinterface

interface ppt_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] shrunk_value;
  logic        [1:0]  zone;
  logic               saturated;
  logic               config_error;
  modport source (output valid, shrunk_value, zone, saturated, config_error, input ready);
  modport sink   (input valid, shrunk_value, zone, saturated, config_error, output ready);
endinterface

@@ hdl/penalty_proximal_threshold.sv @@
// Top level of the proximal threshold block: registers, front, queue, back.
// Depends on ppt_pkg, ppt_if, ppt_regs, ppt_front, ppt_queue, ppt_back.
//
// One coefficient per clock enters and one result per clock leaves when both
// channels flow. Items pass through three front stages (threshold,
// products, classification), the four-entry queue, a 64-stage restoring
// divider that retires one quotient bit per stage (every mode passes
// through it, with divisor one where no division is needed), and the output
// register. A stall on the output freezes the divider pipeline; the queue
// absorbs the front until it fills, then input ready drops.
`timescale 1ns / 1ps
module penalty_proximal_threshold #(
  parameter int FRAC_BITS = ppt_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ppt_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  ppt_in_if.sink                      in_ch,
  ppt_out_if.source                   out_ch
);
  import ppt_pkg::*;

  ppt_cfg_t  cfg;
  ppt_item_t push_item, head;
  logic      push, pop, q_empty, q_full;

  ppt_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ppt_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .in_ch  (in_ch),
    .q_full (q_full),
    .push   (push),
    .item   (push_item)
  );

  ppt_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (push_item),
    .pop   (pop),
    .dout  (head),
    .empty (q_empty),
    .full  (q_full)
  );

  ppt_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .head    (head),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule

@@ hdl/ppt_regs.sv @@
// APB configuration registers: penalty mode, lambda, gamma.
// Depends on ppt_pkg.
`timescale 1ns / 1ps
module ppt_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ppt_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output ppt_pkg::ppt_cfg_t           cfg
);
  import ppt_pkg::*;

  logic       wr;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[PADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode   <= MODE_LASSO;
      cfg.lambda <= '0;
      cfg.gamma  <= GAMMA_RESET;
    end else if (wr) begin
      case (idx)
        REG_MODE:   cfg.mode   <= mode_t'(pwdata[1:0]);
        REG_LAMBDA: cfg.lambda <= pwdata;
        REG_GAMMA:  cfg.gamma  <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_MODE:   prdata = {30'd0, cfg.mode};
      REG_LAMBDA: prdata = cfg.lambda;
      REG_GAMMA:  prdata = {8'd0, cfg.gamma};
      default:    prdata = '0;
    endcase
  end

endmodule

@@ hdl/ppt_front.sv @@
// Front end: takes items, forms the threshold and products, classifies
// each item into a dividend/divisor pair for the back end. Depends on ppt_pkg.
`timescale 1ns / 1ps
module ppt_front #(
  parameter int FRAC_BITS = ppt_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  ppt_pkg::ppt_cfg_t  cfg,
  ppt_in_if.sink             in_ch,
  input  logic               q_full,
  output logic               push,
  output ppt_pkg::ppt_item_t item
);
  import ppt_pkg::*;

  localparam logic [25:0] ONE     = 26'd1 << FRAC_BITS;
  localparam logic [25:0] TWO_ONE = ONE << 1;
  localparam int          LW      = 64 - FRAC_BITS;  // bits of the threshold

  logic en;
  assign en          = !q_full;
  assign in_ch.ready = en;

  // stage 1: magnitude, lambda*w, gamma derived values
  logic        v1, neg1, err1;
  logic [31:0] a1;
  logic [63:0] p1;
  mode_t       mode1;
  logic [23:0] g1, gm1_1, gm2_1;

  logic        neg_c;
  logic [31:0] a_c;
  logic [63:0] p_c;
  logic [25:0] gx, gd1, gd2;
  logic        err_c;

  assign neg_c = in_ch.coefficient[31];
  assign a_c   = neg_c ? (~in_ch.coefficient + 32'd1) : in_ch.coefficient;
  assign p_c   = cfg.lambda * in_ch.weight;
  assign gx    = {2'b00, cfg.gamma};
  assign gd1   = gx - ONE;
  assign gd2   = gx - TWO_ONE;
  assign err_c = ((cfg.mode == MODE_MCP) && (gx <= ONE)) ||
                 ((cfg.mode == MODE_SCAD) && (gx <= TWO_ONE));

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= in_ch.valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg1  <= neg_c;
      a1    <= a_c;
      p1    <= p_c;
      mode1 <= cfg.mode;
      g1    <= cfg.gamma;
      gm1_1 <= gd1[23:0];
      gm2_1 <= gd2[23:0];
      err1  <= err_c;
    end
  end

  // stage 2: threshold compares and partial products of gamma*l
  logic [63:0] l1;
  logic [55:0] gllo_c, glhi_c, ga_c;
  assign l1     = p1 >> FRAC_BITS;
  assign gllo_c = g1 * l1[31:0];
  assign glhi_c = g1 * l1[LW-1:32];
  assign ga_c   = gm1_1 * a1;

  logic        v2, neg2, err2, le_l2, le_2l2;
  logic [31:0] a2, d2;
  logic [63:0] l2;
  mode_t       mode2;
  logic [23:0] g2, gm1_2, gm2_2;
  logic [55:0] gllo2, ga2;
  logic [31:0] glhi2;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg2   <= neg1;
      err2   <= err1;
      a2     <= a1;
      mode2  <= mode1;
      g2     <= g1;
      gm1_2  <= gm1_1;
      gm2_2  <= gm2_1;
      l2     <= l1;
      d2     <= a1 - l1[31:0];
      le_l2  <= {32'd0, a1} <= l1;
      le_2l2 <= {33'd0, a1} <= {l1, 1'b0};
      gllo2  <= gllo_c;
      glhi2  <= glhi_c[31:0];
      ga2    <= ga_c;
    end
  end

  // stage 3: gamma*l modulo 2^64, (a-l)*gamma, ridge operands
  logic        v3, neg3, err3, le_l3, le_2l3;
  logic [31:0] a3, d3;
  mode_t       mode3;
  logic [23:0] gm1_3, gm2_3;
  logic [55:0] ga3, dg3;
  logic [63:0] gl3, ash3, rdiv3;
  logic [55:0] dg_c;
  assign dg_c = d2 * g2;

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg3   <= neg2;
      err3   <= err2;
      le_l3  <= le_l2;
      le_2l3 <= le_2l2;
      a3     <= a2;
      d3     <= d2;
      mode3  <= mode2;
      gm1_3  <= gm1_2;
      gm2_3  <= gm2_2;
      ga3    <= ga2;
      dg3    <= dg_c;
      gl3    <= {8'd0, gllo2} + {glhi2, 32'd0};
      ash3   <= {32'd0, a2} << FRAC_BITS;
      rdiv3  <= 64'(ONE) + {l2[62:0], 1'b0};
    end
  end

  // classification into the queue
  logic        le_gl;
  logic [63:0] num;
  assign le_gl = ash3 <= gl3;
  assign num   = {8'd0, ga3} - gl3;
  assign push  = en && v3;

  always_comb begin
    item.dividend = '0;
    item.divisor  = 64'd1;
    item.neg      = neg3;
    item.zone     = ZONE_ZERO;
    item.err      = 1'b0;
    case (mode3)
      MODE_LASSO: begin
        if (!le_l3) begin
          item.dividend = {32'd0, d3};
          item.zone     = ZONE_SOFT;
        end
      end
      MODE_MCP: begin
        if (err3) begin
          item.neg = 1'b0;
          item.err = 1'b1;
        end else if (le_l3) begin
          item.zone = ZONE_ZERO;
        end else if (le_gl) begin
          item.dividend = {8'd0, dg3};
          item.divisor  = {40'd0, gm1_3};
          item.zone     = ZONE_SCALED;
        end else begin
          item.dividend = {32'd0, a3};
          item.zone     = ZONE_KEPT;
        end
      end
      MODE_SCAD: begin
        if (err3) begin
          item.neg = 1'b0;
          item.err = 1'b1;
        end else if (le_2l3) begin
          if (!le_l3) begin
            item.dividend = {32'd0, d3};
            item.zone     = ZONE_SOFT;
          end
        end else if (le_gl) begin
          item.dividend = num;
          item.divisor  = {40'd0, gm2_3};
          item.zone     = ZONE_SCALED;
        end else begin
          item.dividend = {32'd0, a3};
          item.zone     = ZONE_KEPT;
        end
      end
      MODE_RIDGE: begin
        item.dividend = ash3;
        item.divisor  = rdiv3;
        item.zone     = ZONE_SCALED;
      end
      default: ;
    endcase
  end

endmodule

@@ hdl/ppt_queue.sv @@
// Short FIFO of classified items between front and back ends.
// Depends on ppt_pkg and the assertion macro header.
`timescale 1ns / 1ps
module ppt_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  ppt_pkg::ppt_item_t din,
  input  logic               pop,
  output ppt_pkg::ppt_item_t dout,
  output logic               empty,
  output logic               full
);
  import ppt_pkg::*;
  `include "penalty_proximal_threshold_macros.svh"

  ppt_item_t       slots [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr, rd_ptr;
  logic [Q_CW-1:0] cnt;

  assign empty = (cnt == '0);
  assign full  = (cnt == Q_CW'(Q_DEPTH));
  assign dout  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      cnt <= cnt + Q_CW'(push) - Q_CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= din;
  end

  `PPT_ASSERT_IMP(a_push_room, push, !full, "queue push while full")
  `PPT_ASSERT_IMP(a_pop_data, pop, !empty, "queue pop while empty")
  `PPT_ASSERT_NXT(a_count_up, push && !pop, cnt == $past(cnt) + 1'b1, "queue count lost a push")
  `PPT_ASSERT_NXT(a_count_down, pop && !push, cnt == $past(cnt) - 1'b1, "queue count lost a pop")

endmodule

@@ hdl/ppt_back.sv @@
// Back end: pipelined restoring divider, one quotient bit per stage,
// then saturation, sign and the output register. Depends on ppt_pkg.
`timescale 1ns / 1ps
module ppt_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  input  ppt_pkg::ppt_item_t head,
  output logic               pop,
  ppt_out_if.source          out_ch
);
  import ppt_pkg::*;

  localparam int STAGES = DIV_W;

  typedef struct packed {
    logic [DIV_W-1:0] rem;
    logic [DIV_W-1:0] dq;       // dividend shifts out, quotient shifts in
    logic [DIV_W-1:0] divisor;
    logic             neg;
    logic [1:0]       zone;
    logic             err;
  } div_st_t;

  function automatic div_st_t div_step(input div_st_t s);
    logic [DIV_W:0] r2;
    logic [DIV_W:0] diff;
    logic           qb;
    div_st_t        o;
    r2   = {s.rem, s.dq[DIV_W-1]};
    diff = r2 - {1'b0, s.divisor};
    qb   = !diff[DIV_W];
    o    = s;
    o.rem = qb ? diff[DIV_W-1:0] : r2[DIV_W-1:0];
    o.dq  = {s.dq[DIV_W-2:0], qb};
    return o;
  endfunction

  logic              en, out_valid;
  logic [STAGES-1:0] vld;
  div_st_t           st [STAGES];
  div_st_t           s0;

  assign en           = !out_valid || out_ch.ready;
  assign pop          = en && !q_empty;
  assign out_ch.valid = out_valid;

  always_comb begin
    s0.rem     = '0;
    s0.dq      = head.dividend;
    s0.divisor = head.divisor;
    s0.neg     = head.neg;
    s0.zone    = head.zone;
    s0.err     = head.err;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld       <= {vld[STAGES-2:0], !q_empty};
      out_valid <= vld[STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) st[0] <= div_step(s0);
  end

  for (genvar i = 1; i < STAGES; i++) begin : g_div
    always_ff @(posedge clk) begin
      if (en) st[i] <= div_step(st[i-1]);
    end
  end

  // clamp the magnitude to the signed range, then apply the sign
  logic [DIV_W-1:0] q;
  logic [31:0]      mag;
  logic             sat;
  assign q = st[STAGES-1].dq;

  always_comb begin
    mag = q[31:0];
    sat = 1'b0;
    if (!st[STAGES-1].neg && (q > 64'h7FFF_FFFF)) begin
      mag = 32'h7FFF_FFFF;
      sat = 1'b1;
    end else if (st[STAGES-1].neg && (q > 64'h8000_0000)) begin
      mag = 32'h8000_0000;
      sat = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_ch.shrunk_value <= st[STAGES-1].neg ? (~mag + 32'd1) : mag;
      out_ch.zone         <= st[STAGES-1].zone;
      out_ch.saturated    <= sat;
      out_ch.config_error <= st[STAGES-1].err;
    end
  end

endmodule

@@ verif/tb_penalty_proximal_threshold.sv @@
// Self-checking testbench for penalty_proximal_threshold: lasso, MCP, SCAD and ridge
// thresholding checked against an in-bench predictor under random input and output stalls.
// Depends on ppt_pkg, ppt_if and the RTL top level.
`timescale 1ns / 1ps
module tb_penalty_proximal_threshold;
  import ppt_pkg::*;

  localparam int          FB        = FRAC_BITS_DEF;
  localparam logic [63:0] ONE_Q     = 64'd1 << FB;
  localparam int          CYC_LIMIT = 600000;
  localparam int          N_DIR     = 21;
  localparam int          N_PHASE   = 10;
  localparam int          PHASE_LEN = 50;

  typedef struct packed {
    logic signed [31:0] value;
    logic [1:0]         zone;
    logic               sat;
    logic               err;
  } prox_res_t;

  typedef struct packed {
    mode_t       mode;
    logic [31:0] lam;
    logic [23:0] gam;
    logic [31:0] coef;
    logic [31:0] wt;
    logic        typed;
    prox_res_t   res;
  } stim_row_t;

  localparam logic [23:0] G37 = GAMMA_RESET;

  localparam stim_row_t DIRECTED [N_DIR] = '{
    '{MODE_LASSO, 32'h0, G37, 32'h5, 32'h1, 1'b1, '{32'h5, ZONE_SOFT, 1'b0, 1'b0}},
    '{MODE_LASSO, 32'h0, G37, 32'h0, 32'h1, 1'b1, '{32'h0, ZONE_ZERO, 1'b0, 1'b0}},
    '{MODE_LASSO, 32'h0, G37, 32'h80000000, 32'hFFFFFFFF, 1'b1,
      '{32'h80000000, ZONE_SOFT, 1'b0, 1'b0}},
    '{MODE_LASSO, 32'h0, G37, 32'h7FFFFFFF, 32'h0, 1'b1,
      '{32'h7FFFFFFF, ZONE_SOFT, 1'b0, 1'b0}},
    '{MODE_LASSO, 32'h10000, G37, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0, '0},
    '{MODE_LASSO, 32'h10000, G37, 32'h30000, 32'h10000, 1'b0, '0},
    '{MODE_MCP, 32'h10000, G37, 32'h8000, 32'h10000, 1'b0, '0},
    '{MODE_MCP, 32'h10000, G37, 32'h20000, 32'h10000, 1'b0, '0},
    '{MODE_MCP, 32'h10000, G37, 32'hFFFB0000, 32'h10000, 1'b0, '0},
    '{MODE_MCP, 32'h10000, 24'h10000, 32'h123, 32'h1, 1'b1, '{32'h0, ZONE_ZERO, 1'b0, 1'b1}},
    '{MODE_MCP, 32'h10000, 24'h0, 32'h123, 32'h1, 1'b1, '{32'h0, ZONE_ZERO, 1'b0, 1'b1}},
    '{MODE_SCAD, 32'h10000, 24'h20000, 32'h123, 32'h1, 1'b1,
      '{32'h0, ZONE_ZERO, 1'b0, 1'b1}},
    '{MODE_SCAD, 32'h10000, 24'hFFFFFF, 32'h30000, 32'h10000, 1'b0, '0},
    '{MODE_SCAD, 32'h10000, G37, 32'h18000, 32'h10000, 1'b0, '0},
    '{MODE_SCAD, 32'h10000, G37, 32'h50000, 32'h10000, 1'b0, '0},
    '{MODE_SCAD, 32'h10000, G37, 32'hFFFD0000, 32'h10000, 1'b0, '0},
    '{MODE_RIDGE, 32'h0, G37, 32'h7, 32'h1, 1'b1, '{32'h7, ZONE_SCALED, 1'b0, 1'b0}},
    '{MODE_RIDGE, 32'hFFFFFFFF, G37, 32'h80000000, 32'hFFFFFFFF, 1'b0, '0},
    '{MODE_RIDGE, 32'h8000, G37, 32'h7FFFFFFF, 32'h10000, 1'b0, '0},
    '{MODE_MCP, 32'hFFFFFFFF, 24'hFFFFFF, 32'h80000000, 32'hFFFFFFFF, 1'b0, '0},
    '{MODE_LASSO, 32'hFFFFFFFF, G37, 32'h1, 32'h0, 1'b0, '0}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  ppt_in_if  in_ch ();
  ppt_out_if out_ch ();

  penalty_proximal_threshold u_dut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  always #10 clk = ~clk;

  mode_t       cur_mode;
  logic [31:0] cur_lambda;
  logic [23:0] cur_gamma;
  prox_res_t   pending_q[$];
  int          n_errors = 0;
  int          n_sent = 0;
  int          n_checked = 0;
  int          n_cfg = 0;
  int          cycles = 0;

  function automatic prox_res_t shrink_predict(logic [31:0] x, logic [31:0] w);
    logic [63:0] a, l, g, mag, num;
    logic        neg;
    logic [1:0]  zn;
    prox_res_t   r;
    neg = x[31];
    a = neg ? (64'h1_0000_0000 - {32'b0, x}) : {32'b0, x};
    l = ({32'b0, cur_lambda} * {32'b0, w}) >> FB;
    g = {40'b0, cur_gamma};
    r = '0;
    if ((cur_mode == MODE_MCP && g <= ONE_Q) || (cur_mode == MODE_SCAD && g <= 2 * ONE_Q)) begin
      r.err = 1'b1;
      return r;
    end
    case (cur_mode)
      MODE_LASSO: begin
        if (a <= l) begin mag = 0; zn = ZONE_ZERO; end
        else begin mag = a - l; zn = ZONE_SOFT; end
      end
      MODE_MCP: begin
        if (a <= l) begin mag = 0; zn = ZONE_ZERO; end
        else if ((a << FB) <= g * l) begin
          mag = ((a - l) * g) / (g - ONE_Q); zn = ZONE_SCALED;
        end else begin mag = a; zn = ZONE_KEPT; end
      end
      MODE_SCAD: begin
        if (a <= l) begin mag = 0; zn = ZONE_ZERO; end
        else if (a <= 2 * l) begin mag = a - l; zn = ZONE_SOFT; end
        else if ((a << FB) <= g * l) begin
          num = (g - ONE_Q) * a - g * l;
          mag = num / (g - 2 * ONE_Q); zn = ZONE_SCALED;
        end else begin mag = a; zn = ZONE_KEPT; end
      end
      default: begin
        mag = (a << FB) / (ONE_Q + 2 * l); zn = ZONE_SCALED;
      end
    endcase
    if (!neg && mag > 64'h7FFFFFFF) begin mag = 64'h7FFFFFFF; r.sat = 1'b1; end
    if (neg && mag > 64'h80000000) begin mag = 64'h80000000; r.sat = 1'b1; end
    mag = neg ? (64'd0 - mag) : mag;
    r.value = mag[31:0];
    r.zone = zn;
    return r;
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic reg_write(reg_idx_t idx, logic [31:0] data);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= PADDR_W'(idx) << 2; pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // all registers rewritten, only once the pipe has emptied
  task automatic set_penalty(mode_t m, logic [31:0] lam, logic [23:0] gam);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_q.size() != 0) @(posedge clk);
    reg_write(REG_MODE, 32'(m));
    reg_write(REG_LAMBDA, lam);
    reg_write(REG_GAMMA, 32'(gam));
    cur_mode = m; cur_lambda = lam; cur_gamma = gam;
    n_cfg++;
  endtask

  task automatic send_coef(logic [31:0] c, logic [31:0] w, logic typed, prox_res_t res);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.coefficient <= c;
    in_ch.weight <= w;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    pending_q.push_back(typed ? res : shrink_predict(c, w));
    n_sent++;
  endtask

  // result side: compare on transfer, then draw the next stall
  int stall_left = 0;
  always @(posedge clk) begin
    prox_res_t exp_r;
    prox_res_t got;
    cycles <= cycles + 1;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.shrunk_value, out_ch.zone, out_ch.saturated, out_ch.config_error};
        if (pending_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          n_errors++;
        end else begin
          exp_r = pending_q.pop_front();
          n_checked++;
          if (got !== exp_r) begin
            $display("%0t: mismatch expected val=%h zone=%0d sat=%0d err=%0d",
                     $time, exp_r.value, exp_r.zone, exp_r.sat, exp_r.err);
            $display("%0t:          actual   val=%h zone=%0d sat=%0d err=%0d",
                     $time, got.value, got.zone, got.sat, got.err);
            n_errors++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ch.ready <= 1'b0;
      end else begin
        stall_left <= pick_gap();
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CYC_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending_q.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    logic [63:0] l, a;
    logic [31:0] lam, c, w;
    logic [23:0] gam;
    int          p;
    in_ch.valid = 1'b0;
    in_ch.coefficient = '0;
    in_ch.weight = '0;
    cur_mode = MODE_LASSO; cur_lambda = '0; cur_gamma = GAMMA_RESET;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].mode != cur_mode || DIRECTED[i].lam != cur_lambda ||
          DIRECTED[i].gam != cur_gamma)
        set_penalty(DIRECTED[i].mode, DIRECTED[i].lam, DIRECTED[i].gam);
      send_coef(DIRECTED[i].coef, DIRECTED[i].wt, DIRECTED[i].typed, DIRECTED[i].res);
    end

    for (int ph = 0; ph < N_PHASE; ph++) begin
      p = $urandom_range(0, 9);
      lam = (p == 0) ? 32'h0 : (p == 1) ? 32'hFFFFFFFF :
            (p < 8) ? $urandom_range(1, 32'h30000) : $urandom;
      p = $urandom_range(0, 11);
      case (p)
        0: gam = 24'h0;
        1: gam = 24'(ONE_Q);
        2: gam = 24'(ONE_Q) + 24'd1;
        3: gam = 24'(2 * ONE_Q);
        4: gam = 24'(2 * ONE_Q) + 24'd1;
        5: gam = 24'hFFFFFF;
        default: gam = 24'($urandom_range(32'h20001, 32'hA0000));
      endcase
      set_penalty(mode_t'(ph % 4), lam, gam);
      for (int k = 0; k < PHASE_LEN; k++) begin
        w = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h40000);
        if ($urandom_range(0, 3) == 0) begin
          c = $urandom;
        end else begin
          // magnitude placed around the threshold to land in every zone
          l = ({32'b0, lam} * {32'b0, w}) >> FB;
          a = (l * $urandom_range(0, 5 << FB)) >> FB;
          if (a > 64'h7FFFFFFF) a = 64'h7FFFFFFF;
          c = $urandom_range(0, 1) ? -a[31:0] : a[31:0];
        end
        send_coef(c, w, 1'b0, '0);
      end
    end

    in_ch.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    $display("covered %0d coefficients over %0d penalty settings, %0d results checked",
             n_sent, n_cfg, n_checked);
    $display("modes lasso/MCP/SCAD/ridge with invalid and extreme gamma and lambda");
    if (n_errors == 0 && pending_q.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hdl
hdl/ppt_pkg.sv
hdl/ppt_if.sv
hdl/ppt_regs.sv
hdl/ppt_front.sv
hdl/ppt_queue.sv
hdl/ppt_back.sv
hdl/penalty_proximal_threshold.sv
verif/tb_penalty_proximal_threshold.sv
